@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the section tracker RTL.
// All of them sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/prst_pkg.sv @@
// ----------------------------------------------------------------------------
// prst_pkg
// Shared types and codes of the partial refresh section tracker.
// ----------------------------------------------------------------------------
package prst_pkg;

  localparam int MAX_SECTIONS = 32;
  localparam int CFG_IDX_W    = 2;

  // Operation codes; any other code is a query.
  localparam logic [1:0] OP_FREE  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTIONS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERLEAVE = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] address;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic [31:0] refresh_off_mask;
    logic        out_of_map;
    logic        count_error;
    logic [5:0]  refreshed_count;
    logic [5:0]  stopped_count;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic check;
    logic update;
    logic cnt1;
    logic cnt2;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic skip;
    logic oom_hit;
    logic last_seg;
  } ctrl_sts_t;

endpackage

@@ rtl/partial_refresh_section_tracker.sv @@
// ----------------------------------------------------------------------------
// partial_refresh_section_tracker
// A transaction is loaded, then each section it touches gets one address
// check and one counter read-modify-write; a query or zero length goes
// straight to the mask count, and a walk that leaves the map ends at that
// section's check. One transaction at a time; the mask is counted in two
// steps, and the next start is taken in the cycle the result is shown.
// The receiver cannot stall the result strobe.
// Reset clears the mask and all counters at once (no clearing pass).
// ----------------------------------------------------------------------------
module partial_refresh_section_tracker #(
  parameter int SECTION_BITS     = 26,
  parameter int SECTIONS_PER_DIE = 8,
  parameter int DIES             = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel
  input  logic                             start_i,
  input  prst_pkg::req_t                   req_i,
  output logic                             busy_o,
  // Result channel
  output logic                             done_o,
  output prst_pkg::rsp_t                   result_o,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [prst_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [31:0]                      cfg_data_i
);
  import prst_pkg::*;

  // The tracker cuts memory into sections of 2^SECTION_BITS bytes, laid
  // end to end from the map base. A free transaction adds to each section
  // the bytes it covers there; an allocate transaction subtracts them. Each
  // section keeps a free-byte counter in a small RAM; a valid bit per
  // section makes an unwritten counter read as zero, the reset value.
  // A second flag per section marks it wholly free, so the twin check in
  // interleaved mode needs no second RAM read.

  // Configuration registers: user writes them only while idle; unenforced.
  logic [31:0] map_base_q;
  logic [5:0]  sections_q;
  logic        interleave_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_base_q   <= '0;
      sections_q   <= 6'd32;
      interleave_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAP_BASE:   map_base_q   <= cfg_data_i;
        CFG_SECTIONS:   sections_q   <= cfg_data_i[5:0];
        CFG_INTERLEAVE: interleave_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // The controller sequences each transaction: one address check and one
  // counter update per section, then a two-step count of the mask.
  prst_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  // The datapath holds the walk position, counters, mask and result.
  prst_dp #(
    .SECTION_BITS     (SECTION_BITS),
    .SECTIONS_PER_DIE (SECTIONS_PER_DIE),
    .DIES             (DIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .map_base_i   (map_base_q),
    .sections_i   (sections_q),
    .interleave_i (interleave_q),
    .result_o     (result_o),
    .done_o       (done_o)
  );

endmodule

@@ rtl/prst_ram.sv @@
// ----------------------------------------------------------------------------
// prst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module prst_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/prst_ctrl.sv @@
// ----------------------------------------------------------------------------
// prst_ctrl
// Sequencer: walks a request section by section, then counts the mask.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  prst_pkg::ctrl_sts_t   sts_i,
  output prst_pkg::ctrl_cmd_t   cmd_o,
  output logic                  busy_o
);
  import prst_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADDR = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_CNT1 = 3'd3;
  localparam logic [2:0] ST_CNT2 = 3'd4;

  logic [2:0] state_q, state_d;
  ctrl_cmd_t  cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd.load = 1'b1;
          state_d  = sts_i.skip ? ST_CNT1 : ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.check = 1'b1;
        state_d   = sts_i.oom_hit ? ST_CNT1 : ST_UPD;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
        state_d    = sts_i.last_seg ? ST_CNT1 : ST_ADDR;
      end
      ST_CNT1: begin
        cmd.cnt1 = 1'b1;
        state_d  = ST_CNT2;
      end
      ST_CNT2: begin
        cmd.cnt2 = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != ST_IDLE);

  `ASSERT_ALWAYS(a_cmd_onehot0, $onehot0(cmd), "more than one datapath command at once")
  `ASSERT_IMPL(a_upd_follows_addr, state_q == ST_UPD, $past(state_q) == ST_ADDR, "section update without address check")
  `ASSERT_NEXT(a_load_leaves_idle, cmd.load, state_q == ST_ADDR || state_q == ST_CNT1, "accepted transaction did not start")

endmodule

@@ rtl/prst_dp.sv @@
// ----------------------------------------------------------------------------
// prst_dp
// Datapath: address split, free-byte counters, refresh mask and counts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prst_dp #(
  parameter int SECTION_BITS     = 26,
  parameter int SECTIONS_PER_DIE = 8,
  parameter int DIES             = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prst_pkg::req_t      req_i,
  input  prst_pkg::ctrl_cmd_t cmd_i,
  output prst_pkg::ctrl_sts_t sts_o,
  input  logic [31:0]         map_base_i,
  input  logic [5:0]          sections_i,
  input  logic                interleave_i,
  output prst_pkg::rsp_t      result_o,
  output logic                done_o
);
  import prst_pkg::*;

  localparam int TOTAL = DIES * SECTIONS_PER_DIE;
  localparam int NSECT = (TOTAL > MAX_SECTIONS) ? MAX_SECTIONS : TOTAL;
  localparam int IDX_W = (NSECT > 1) ? $clog2(NSECT) : 1;
  localparam int FB_W  = SECTION_BITS + 1;
  localparam logic [FB_W-1:0] SEC_SIZE = {1'b1, {SECTION_BITS{1'b0}}};

  // Twin lookup, fixed by the geometry.
  logic [IDX_W-1:0] twin_idx [NSECT];
  logic [NSECT-1:0] twin_ok;

  for (genvar g = 0; g < NSECT; g++) begin : g_twin
    localparam int TDIE = (g / SECTIONS_PER_DIE) ^ 1;
    localparam int TW   = TDIE * SECTIONS_PER_DIE + (g % SECTIONS_PER_DIE);
    if (TDIE < DIES && TW < NSECT) begin : g_has
      assign twin_idx[g] = IDX_W'(TW);
      assign twin_ok[g]  = 1'b1;
    end else begin : g_none
      assign twin_idx[g] = '0;
      assign twin_ok[g]  = 1'b0;
    end
  end

  logic [5:0]       mapped;
  logic [NSECT-1:0] mapped_bits;

  assign mapped = (sections_i > 6'(NSECT)) ? 6'(NSECT) : sections_i;

  always_comb begin
    for (int i = 0; i < NSECT; i++) begin
      mapped_bits[i] = (6'(i) < mapped);
    end
  end

  // Walk registers.
  logic             free_op_q;
  logic [32:0]      addr_q;
  logic [31:0]      len_q;
  logic [IDX_W-1:0] idx_q;
  logic [FB_W-1:0]  cur_q;
  logic             oom_q, cerr_q;

  // Section state.
  logic [NSECT-1:0] mask_q, mask_d;
  logic [NSECT-1:0] full_q;
  logic [NSECT-1:0] valid_q;

  // Count pipeline and result.
  logic [2:0] grp_q [8];
  logic [2:0] grp_d [8];
  rsp_t       result_q;
  logic       done_q;

  // Address check.
  logic [32:0]      off, idx_wide;
  logic             oom_hit;
  logic [IDX_W-1:0] idx_d;
  logic [FB_W-1:0]  rem, cur_d;

  assign off      = addr_q - {1'b0, map_base_i};
  assign idx_wide = off >> SECTION_BITS;
  assign oom_hit  = (addr_q < {1'b0, map_base_i}) || (idx_wide >= 33'(mapped));
  assign idx_d    = idx_wide[IDX_W-1:0];
  assign rem      = SEC_SIZE - {1'b0, off[SECTION_BITS-1:0]};
  assign cur_d    = (len_q < 32'(rem)) ? len_q[FB_W-1:0] : rem;

  // Counter update.
  logic [FB_W-1:0]  rd_data, fb, new_free;
  logic [FB_W:0]    sum;
  logic             upd_err, fire, tw_has, tw_full;
  logic [IDX_W-1:0] tw_idx;

  prst_ram #(
    .WIDTH (FB_W),
    .DEPTH (NSECT)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (idx_q),
    .wdata_i (new_free),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  assign fb  = valid_q[idx_q] ? rd_data : '0;
  assign sum = {1'b0, fb} + {1'b0, cur_q};

  always_comb begin
    if (free_op_q) begin
      upd_err  = (sum > {1'b0, SEC_SIZE});
      new_free = upd_err ? SEC_SIZE : sum[FB_W-1:0];
      fire     = (new_free == SEC_SIZE);
    end else begin
      upd_err  = (cur_q > fb);
      new_free = upd_err ? '0 : (fb - cur_q);
      fire     = (fb == SEC_SIZE);
    end
  end

  assign tw_idx  = twin_idx[idx_q];
  assign tw_has  = interleave_i && twin_ok[idx_q] && (6'(tw_idx) < mapped);
  assign tw_full = full_q[tw_idx];

  always_comb begin
    mask_d = mask_q;
    if (cmd_i.update && fire) begin
      if (!tw_has) begin
        mask_d[idx_q] = free_op_q;
      end else if (tw_full) begin
        mask_d[idx_q]  = free_op_q;
        mask_d[tw_idx] = free_op_q;
      end
    end
  end

  // Popcount of stopped, mapped sections in groups of four.
  logic [31:0] stop_vec;
  logic [5:0]  stop_sum;

  assign stop_vec = 32'(mask_q & mapped_bits);

  always_comb begin
    for (int g = 0; g < 8; g++) begin
      grp_d[g] = 3'(stop_vec[4*g]) + 3'(stop_vec[4*g+1])
               + 3'(stop_vec[4*g+2]) + 3'(stop_vec[4*g+3]);
    end
  end

  always_comb begin
    stop_sum = '0;
    for (int g = 0; g < 8; g++) begin
      stop_sum = stop_sum + 6'(grp_q[g]);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      free_op_q <= (req_i.operation == OP_FREE);
      addr_q    <= {1'b0, req_i.address};
      len_q     <= req_i.length;
      oom_q     <= 1'b0;
      cerr_q    <= 1'b0;
    end
    if (cmd_i.check) begin
      idx_q <= idx_d;
      cur_q <= cur_d;
      if (oom_hit) begin
        oom_q <= 1'b1;
      end
    end
    if (cmd_i.update) begin
      addr_q <= addr_q + 33'(cur_q);
      len_q  <= len_q - 32'(cur_q);
      if (upd_err) begin
        cerr_q <= 1'b1;
      end
    end
    if (cmd_i.cnt1) begin
      grp_q <= grp_d;
    end
    if (cmd_i.cnt2) begin
      result_q.refresh_off_mask <= 32'(mask_q);
      result_q.out_of_map       <= oom_q;
      result_q.count_error      <= cerr_q;
      result_q.refreshed_count  <= mapped - stop_sum;
      result_q.stopped_count    <= stop_sum;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      full_q  <= '0;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      mask_q <= mask_d;
      done_q <= cmd_i.cnt2;
      if (cmd_i.update) begin
        valid_q[idx_q] <= 1'b1;
        full_q[idx_q]  <= (new_free == SEC_SIZE);
      end
    end
  end

  assign sts_o.skip     = ((req_i.operation != OP_FREE) && (req_i.operation != OP_ALLOC))
                          || (req_i.length == '0);
  assign sts_o.oom_hit  = oom_hit;
  assign sts_o.last_seg = (len_q == 32'(cur_q));

  assign result_o = result_q;
  assign done_o   = done_q;

  `ASSERT_IMPL(a_done_after_count, done_q, $past(cmd_i.cnt2), "result strobe without count step")
  `ASSERT_NEXT(a_mask_on_update, !cmd_i.update, $stable(mask_q), "refresh mask moved outside an update")
  `ASSERT_IMPL(a_full_is_valid, 1'b1, (full_q & ~valid_q) == '0, "full flag on a section never written")

endmodule

@@ sim/partial_refresh_section_tracker_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partial_refresh_section_tracker_test
// Self-checking bench for the refresh section tracker. Free, allocate and
// query transactions go in under several map settings. An in-bench model of
// the section counters and the refresh-off mask predicts each result.
// ----------------------------------------------------------------------------
module partial_refresh_section_tracker_test;
  import prst_pkg::*;

  localparam int          SECTION_BITS     = 26;
  localparam int          SECTIONS_PER_DIE = 8;
  localparam int          DIES             = 4;
  localparam logic [63:0] SECTION_SIZE     = 64'd1 << SECTION_BITS;
  localparam int          CLK_PERIOD       = 10;
  // The package only names free and allocate; every other code is a query.
  localparam logic [1:0]  OP_QUERY         = 2'd2;
  localparam logic [1:0]  OP_SPARE         = 2'd3;
  // The slowest transaction walks 32 sections and then leaves the map; the
  // limit also covers idle gaps, drain pauses and register writes.
  localparam int          IDLE_LIMIT       = 3000;
  localparam int          TAIL_CYCLES      = 80;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the registers, the per-section free
  // byte counters and the mask, and queues one predicted result per accepted
  // transaction.
  // --------------------------------------------------------------------------
  class section_tracker_scoreboard;
    logic [31:0] map_base;
    logic [5:0]  sections_in_use;
    logic        interleave_pairs;
    logic [26:0] free_bytes [MAX_SECTIONS];
    logic [31:0] stopped_mask;
    rsp_t        predicted_results [$];
    int unsigned mismatch_count;

    function new();
      map_base         = '0;
      sections_in_use  = 6'd32;
      interleave_pairs = 1'b0;
      foreach (free_bytes[i]) free_bytes[i] = '0;
      stopped_mask     = '0;
      mismatch_count   = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_MAP_BASE:   map_base = data;
        CFG_SECTIONS:   sections_in_use = data[5:0];
        CFG_INTERLEAVE: interleave_pairs = data[0];
        default: ;
      endcase
    endfunction

    // Starts or stops refresh of one section. With pairing on, a section whose
    // twin exists and is mapped only changes together with that twin, and only
    // while the twin is wholly free.
    function void set_section_refresh(int unsigned idx, int unsigned mapped, bit stop);
      int unsigned twin_die;
      int unsigned twin;
      twin_die = (idx / SECTIONS_PER_DIE) ^ 1;
      twin     = twin_die * SECTIONS_PER_DIE + idx % SECTIONS_PER_DIE;
      if (!interleave_pairs || twin_die >= DIES || twin >= mapped) begin
        stopped_mask[idx] = stop;
      end else if (free_bytes[twin] == SECTION_SIZE) begin
        stopped_mask[idx]  = stop;
        stopped_mask[twin] = stop;
      end
    endfunction

    function void note_request(req_t r);
      logic [63:0] addr;
      logic [63:0] len;
      logic [63:0] off;
      logic [63:0] cur;
      logic [63:0] fill;
      int unsigned mapped;
      int unsigned idx;
      rsp_t        want;
      want   = '0;
      mapped = (sections_in_use > MAX_SECTIONS) ? MAX_SECTIONS : sections_in_use;
      addr   = {32'd0, r.address};
      len    = {32'd0, r.length};
      if (r.operation == OP_FREE || r.operation == OP_ALLOC) begin
        // The address runs on past 2^32 when the map sits at the top.
        while (len != 0 && !want.out_of_map) begin
          off = addr - {32'd0, map_base};
          if (addr < {32'd0, map_base} || (off >> SECTION_BITS) >= mapped) begin
            want.out_of_map = 1'b1;
          end else begin
            idx = int'(off >> SECTION_BITS);
            cur = ((64'(idx) + 64'd1) << SECTION_BITS) - off;
            if (len < cur) cur = len;
            if (r.operation == OP_FREE) begin
              fill = {37'd0, free_bytes[idx]} + cur;
              if (fill > SECTION_SIZE) begin
                fill = SECTION_SIZE;
                want.count_error = 1'b1;
              end
              free_bytes[idx] = fill[26:0];
              if (fill == SECTION_SIZE) set_section_refresh(idx, mapped, 1'b1);
            end else begin
              if (free_bytes[idx] == SECTION_SIZE) set_section_refresh(idx, mapped, 1'b0);
              if (cur > {37'd0, free_bytes[idx]}) begin
                free_bytes[idx]  = '0;
                want.count_error = 1'b1;
              end else begin
                free_bytes[idx] = free_bytes[idx] - cur[26:0];
              end
            end
            addr = addr + cur;
            len  = len - cur;
          end
        end
      end
      for (int i = 0; i < mapped; i++) begin
        if (stopped_mask[i]) want.stopped_count++;
        else want.refreshed_count++;
      end
      want.refresh_off_mask = stopped_mask;
      predicted_results.push_back(want);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (predicted_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no transaction pending: mask %h oom %b cerr %b run %0d stop %0d",
                   $time, got.refresh_off_mask, got.out_of_map, got.count_error,
                   got.refreshed_count, got.stopped_count);
        return;
      end
      want = predicted_results.pop_front();
      if (got.refresh_off_mask !== want.refresh_off_mask ||
          got.out_of_map       !== want.out_of_map       ||
          got.count_error      !== want.count_error      ||
          got.refreshed_count  !== want.refreshed_count  ||
          got.stopped_count    !== want.stopped_count) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: expected mask %h oom %b cerr %b run %0d stop %0d", $time,
                   want.refresh_off_mask, want.out_of_map, want.count_error,
                   want.refreshed_count, want.stopped_count);
          $display("%0t: actual   mask %h oom %b cerr %b run %0d stop %0d", $time,
                   got.refresh_off_mask, got.out_of_map, got.count_error,
                   got.refreshed_count, got.stopped_count);
        end
      end
    endfunction

    function int unsigned pending();
      return predicted_results.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test. Every input holds a known value from time zero.
  // --------------------------------------------------------------------------
  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start_i    = 1'b0;
  req_t                 req_i      = '0;
  logic                 busy_o;
  logic                 done_o;
  rsp_t                 result_o;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [31:0]          cfg_data_i = '0;

  partial_refresh_section_tracker #(
    .SECTION_BITS    (SECTION_BITS),
    .SECTIONS_PER_DIE(SECTIONS_PER_DIE),
    .DIES            (DIES)
  ) u_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .req_i     (req_i),
    .busy_o    (busy_o),
    .done_o    (done_o),
    .result_o  (result_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  section_tracker_scoreboard tracker_sb;

  // Settings the stimulus aims at; they follow the last register writes.
  logic [31:0] map_base_now;
  int unsigned mapped_now;
  // Transactions left in the current burst before the sender takes a gap.
  int unsigned burst_left;
  int unsigned idle_cycles;

  // The result is shown for one cycle only, so it is taken at the edge that
  // ends that cycle. Values sampled here are the ones from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) tracker_sb.check_result(result_o);
  end

  // Watchdog: any cycle that moves a transaction either way restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("partial_refresh_section_tracker: mismatch");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks. All of them return right after a rising edge, so each
  // nonblocking assignment they make lands on the next edge.
  // --------------------------------------------------------------------------
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker_sb.set_register(idx, data);
  endtask

  // Writes all three registers back to back; only legal while nothing is in
  // flight.
  task automatic apply_settings(input logic [31:0] base, input logic [5:0] sections,
                                input logic pairs);
    write_register(CFG_MAP_BASE, base);
    write_register(CFG_SECTIONS, {26'd0, sections});
    write_register(CFG_INTERLEAVE, {31'd0, pairs});
    cfg_we_i     <= 1'b0;
    map_base_now = base;
    mapped_now   = (sections > MAX_SECTIONS) ? MAX_SECTIONS : sections;
  endtask

  // Presents one transaction and holds it until the block takes it. Within a
  // burst start stays high, so the next call only swaps the request fields.
  task automatic send_request(input logic [1:0] op, input logic [31:0] address,
                              input logic [31:0] length);
    req_t r;
    r.operation = op;
    r.address   = address;
    r.length    = length;
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    tracker_sb.note_request(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      // Now and then a long burst leaves the block no idle time at all.
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(0, 6);
    end
  endtask

  // Sender holds off until every predicted result has come back.
  task automatic wait_until_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (tracker_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Most transactions are aimed at section borders of the current map, with a
  // bias toward the first two sections of dies 0 and 1 so that twins become
  // wholly free together. One in five is plain noise over the whole space.
  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    int unsigned sect;
    logic [31:0] offset;
    roll = $urandom_range(0, 99);
    if (roll < 45)      r.operation = OP_FREE;
    else if (roll < 85) r.operation = OP_ALLOC;
    else if (roll < 95) r.operation = OP_QUERY;
    else                r.operation = OP_SPARE;
    if ($urandom_range(0, 4) == 0) begin
      r.address = $urandom;
      r.length  = $urandom >> $urandom_range(0, 31);
    end else begin
      if ($urandom_range(0, 1))
        sect = $urandom_range(0, 1) * SECTIONS_PER_DIE + $urandom_range(0, 1);
      else
        sect = $urandom_range(0, mapped_now);
      offset    = $urandom_range(0, 1) ? 32'd0 : ($urandom & (SECTION_SIZE[31:0] - 1));
      r.address = map_base_now + (sect << SECTION_BITS) + offset;
      roll = $urandom_range(0, 99);
      if (roll < 3)       r.length = 32'd0;
      else if (roll < 6)  r.length = 32'hFFFF_FFFF;
      else if (roll < 30) r.length = $urandom_range(1, 3) << SECTION_BITS;
      else if (roll < 33) r.length = $urandom_range(4, 63) << SECTION_BITS;
      else if (roll < 48) r.length = SECTION_SIZE[31:0] - offset;
      else if (roll < 73) r.length = $urandom & (SECTION_SIZE[31:0] - 1);
      else                r.length = $urandom_range(1, 4096);
    end
    return r;
  endfunction

  task automatic run_random_items(input int unsigned count);
    req_t r;
    repeat (count) begin
      r = random_request();
      send_request(r.operation, r.address, r.length);
      if ($urandom_range(0, 49) == 0) wait_until_drained();
    end
    wait_until_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    tracker_sb   = new();
    burst_left   = 0;
    map_base_now = '0;
    mapped_now   = MAX_SECTIONS;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state under the reset register values: both the query code and
    // the unused code only report counts.
    send_request(OP_QUERY, $urandom, $urandom);
    send_request(OP_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_until_drained();

    // Flat map of 32 sections from address zero, no pairing.
    apply_settings(32'h0, 6'd32, 1'b0);
    send_request(OP_FREE,  32'h0, 32'h0);                        // zero length free
    send_request(OP_ALLOC, 32'h0, 32'h0);                        // zero length allocate
    send_request(OP_FREE,  32'h0, SECTION_SIZE[31:0]);           // section 0 stops
    send_request(OP_FREE,  32'h100, 32'h1);                      // counter saturates
    send_request(OP_ALLOC, 32'h0, 32'h1);                        // section 0 restarts
    send_request(OP_ALLOC, 32'h0, SECTION_SIZE[31:0]);           // counter clamps to zero
    send_request(OP_FREE,  32'd30 << SECTION_BITS, 32'hFFFF_FFFF); // runs off the map end
    send_request(OP_FREE,  32'hFFFF_FFFF, 32'h1);                // starts outside the map
    send_request(OP_FREE,  32'h0, 32'hFFFF_FFFF);                // every section, longest walk
    send_request(OP_ALLOC, 32'h7FFF_FFFF, 32'h1);                // last byte of the map
    send_request(OP_ALLOC, 32'h0, 32'hFFFF_FFFF);                // restart all, clamp the last
    send_request(OP_FREE,  32'h0400_0001, 32'd2 << SECTION_BITS); // partial, whole, partial
    run_random_items(100);

    // Same map with twin dies paired.
    apply_settings(32'h0, 6'd32, 1'b1);
    send_request(OP_FREE,  32'h0, SECTION_SIZE[31:0]);           // twin still busy
    send_request(OP_FREE,  32'd8 << SECTION_BITS, SECTION_SIZE[31:0]); // pair stops
    send_request(OP_ALLOC, (32'd8 << SECTION_BITS) + 32'd5, 32'd3);    // pair restarts
    send_request(OP_FREE,  32'd24 << SECTION_BITS, SECTION_SIZE[31:0]); // die 2 twin busy
    run_random_items(100);

    // Map near the top of the address space: walks carry on past 2^32, and
    // with only die 0 mapped every section is unpaired.
    apply_settings(32'hF000_0000, 6'd5, 1'b1);
    run_random_items(100);

    // Unaligned base, die 1 partly mapped so some twins are missing.
    apply_settings(32'h0123_4567, 6'd12, 1'b1);
    run_random_items(100);

    // Single section at the highest base.
    apply_settings(32'hFFFF_FFFF, 6'd1, 1'b0);
    run_random_items(80);

    // Nothing mapped: every free or allocate of nonzero length leaves the map at once.
    apply_settings($urandom, 6'd0, 1'b1);
    run_random_items(40);

    // Section count above the geometry is limited to 32.
    apply_settings($urandom & 32'h7FFF_FFFF, 6'd63, 1'b1);
    run_random_items(100);

    repeat (2) begin
      apply_settings($urandom >> $urandom_range(0, 31), 6'($urandom_range(1, 32)),
                     1'($urandom_range(0, 1)));
      run_random_items(100);
    end

    wait_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker_sb.mismatch_count == 0 && tracker_sb.pending() == 0) begin
      $display("partial_refresh_section_tracker: match");
    end else begin
      $display("partial_refresh_section_tracker: mismatch");
    end
    $finish;
  end

endmodule
